### design/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared constants, register indexes, result modes and the item record that
// passes from the scan cells to the result pipeline.
// ----------------------------------------------------------------------------
package wbps_pkg;

	// Longest pattern and the depth of the byte window.
	localparam int MAX_PATTERN = 32;
	localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);

	// Field widths fixed by the register map.
	localparam int PAT_BYTES = 32;
	localparam int PAT_IDX_W = 5;
	localparam int LEN_W     = 6;
	localparam int OFS_W     = 5;
	localparam int ADDR_W    = 64;
	localparam int WORD_W    = 32;

	// A pattern byte of this value matches any data byte.
	localparam logic [7:0] WILDCARD = 8'h00;

	// Distance from the match address to the end of the relative field.
	localparam logic [ADDR_W-1:0] WORD_BIAS = 64'd7;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PAT0   = 3'd0,
		REG_PAT1   = 3'd1,
		REG_PAT2   = 3'd2,
		REG_PAT3   = 3'd3,
		REG_LENGTH = 3'd4,
		REG_MODE   = 3'd5,
		REG_OFFSET = 3'd6,
		REG_START  = 3'd7
	} cfg_reg_t;

	// Result modes; the remaining code behaves as MODE_ADDR.
	typedef enum logic [1:0] {
		MODE_ADDR = 2'd0,
		MODE_REL  = 2'd1,
		MODE_WORD = 2'd2
	} result_mode_t;

	// One result-bearing item leaving the scan cells.
	typedef struct packed {
		logic              hit;
		logic              word_ok;
		logic [WORD_W-1:0] word;
		logic [ADDR_W-1:0] seen;
	} scan_item_t;

endpackage

### design/wildcard_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Streams a memory range byte by byte through a row of scan cells and reports
// the first place where the loaded wildcard pattern matches.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle for as long as the consumer keeps
// up; the window of 32 scan cells shifts and all cells compare in the same
// cycle as the byte is taken. A result leaves through a three-stage pipeline
// (item capture, address and word arithmetic, output register), and input
// bytes keep flowing while the output holds an unaccepted result until that
// pipeline is full. Load the pattern, length, mode, word offset and start
// address before a range begins; there is no clearing pass after reset.
module wildcard_byte_pattern_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [wbps_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [wbps_pkg::ADDR_W-1:0]   result_value
);
	import wbps_pkg::*;

	logic [3:0][63:0]           pat_q;
	logic [LEN_W-1:0]           len_cfg_q;
	logic [1:0]                 mode_q;
	logic [OFS_W-1:0]           offset_q;
	logic [ADDR_W-1:0]          start_q;
	logic [ADDR_W-1:0]          seen_q;
	logic                       done_q;

	logic [PAT_BYTES*8-1:0]     pat_flat;
	logic [LEN_W-1:0]           len_eff;
	logic                       accept;
	logic                       shift;
	logic [ADDR_W-1:0]          seen_n;
	logic                       enough;
	logic                       hit;
	logic                       load;
	logic                       word_ok;
	logic [WORD_W-1:0]          word;
	scan_item_t                 item;
	logic [7:0]                 cell_q   [MAX_PATTERN];
	logic [7:0]                 cell_nxt [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]     cell_hit;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			len_cfg_q <= LEN_W'(1);
			mode_q    <= MODE_ADDR;
			offset_q  <= '0;
			start_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PAT0:   pat_q[0]  <= cfg_data;
				REG_PAT1:   pat_q[1]  <= cfg_data;
				REG_PAT2:   pat_q[2]  <= cfg_data;
				REG_PAT3:   pat_q[3]  <= cfg_data;
				REG_LENGTH: len_cfg_q <= cfg_data[LEN_W-1:0];
				REG_MODE:   mode_q    <= cfg_data[1:0];
				REG_OFFSET: offset_q  <= cfg_data[OFS_W-1:0];
				REG_START:  start_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign pat_flat = pat_q;

	// A zero length counts as one, and a length beyond the window as full.
	always_comb begin
		if (len_cfg_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_cfg_q > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = len_cfg_q;
		end
	end

	// Handshake: the window shifts only until a range has its answer.
	assign accept = in_valid && !in_stall;
	assign shift  = accept && !done_q;

	// Row of scan cells; cell d holds the byte d places behind the newest.
	for (genvar d = 0; d < MAX_PATTERN; d++) begin : g_cell
		logic [LEN_W-1:0] pidx;
		logic [7:0]       din;

		// Cell d lines up with pattern byte length - 1 - d.
		assign pidx = len_eff - LEN_W'(d) - LEN_W'(1);

		if (d == 0) begin : g_head
			assign din = data_byte;
		end else begin : g_body
			assign din = cell_q[d-1];
		end

		wbps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.din    (din),
			.pat    (pat_flat[{pidx[PAT_IDX_W-1:0], 3'b000} +: 8]),
			.used   (LEN_W'(d) < len_eff),
			.dout   (cell_q[d]),
			.nxt    (cell_nxt[d]),
			.hit    (cell_hit[d])
		);
	end

	// Saturating byte count and the full-window test.
	assign seen_n = (&seen_q) ? seen_q : seen_q + ADDR_W'(1);
	assign enough = (|seen_n[ADDR_W-1:LEN_W]) || (seen_n[LEN_W-1:0] >= len_eff);
	assign hit    = enough && (&cell_hit);

	// The embedded word must lie wholly inside the matched bytes.
	assign word_ok = (LEN_W'(offset_q) + LEN_W'(4)) <= len_eff;

	// Word bytes, little-endian, picked from the cells after this shift.
	for (genvar j = 0; j < 4; j++) begin : g_word
		logic [LEN_W-1:0] widx;

		assign widx = len_eff - LEN_W'(offset_q) - LEN_W'(j) - LEN_W'(1);
		assign word[8*j +: 8] = cell_nxt[widx[WIN_IDX_W-1:0]];
	end

	// An item enters the result pipeline on a match or an unanswered end.
	assign load = shift && (hit || last_byte);

	always_comb begin
		item.hit     = hit;
		item.word_ok = word_ok;
		item.word    = word;
		item.seen    = seen_n;
	end

	// Range state: byte count and answered flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				seen_q <= '0;
				done_q <= 1'b0;
			end else if (shift) begin
				seen_q <= seen_n;
				done_q <= hit;
			end
		end
	end

	wbps_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.item         (item),
		.mode         (mode_q),
		.len          (len_eff),
		.start        (start_q),
		.busy         (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.result_value (result_value)
	);

	// A not-found result always carries a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> result_value == '0)
		else $error("not-found result with non-zero value");

	// An answered range sends nothing more down the pipeline.
	a_one_answer: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !load)
		else $error("second result issued within one range");

	// The last byte of a range starts the next range afresh.
	a_range_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> seen_q == '0 && !done_q)
		else $error("range state not cleared after last byte");

endmodule

### design/wbps_cell.sv
// ----------------------------------------------------------------------------
// Scan cell
// Holds one byte of the sliding window, hands it to the next cell on every
// shift and compares the byte it is about to hold with its pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [7:0] din,
	input  logic [7:0] pat,
	input  logic       used,
	output logic [7:0] dout,
	output logic [7:0] nxt,
	output logic       hit
);
	import wbps_pkg::*;

	logic [7:0] byte_q;

	// The value this cell holds after the current edge.
	assign nxt = shift ? din : byte_q;

	// A cell outside the pattern length, or under a wildcard, always agrees.
	assign hit = !used || (pat == WILDCARD) || (nxt == pat);

	assign dout = byte_q;

	// Window byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

endmodule

### design/wbps_result.sv
// ----------------------------------------------------------------------------
// Result pipeline
// Three registered stages that turn a scan item into the found flag and the
// result value, with a held output register towards the consumer.
// ----------------------------------------------------------------------------
module wbps_result (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  wbps_pkg::scan_item_t         item,
	input  logic [1:0]                   mode,
	input  logic [wbps_pkg::LEN_W-1:0]   len,
	input  logic [wbps_pkg::ADDR_W-1:0]  start,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [wbps_pkg::ADDR_W-1:0]  result_value
);
	import wbps_pkg::*;

	logic                valid_s1;
	scan_item_t          item_s1;
	logic                valid_s2;
	logic                found_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic [ADDR_W-1:0]   sx_s2;
	logic [ADDR_W-1:0]   rel_s2;
	logic                out_valid_q;
	logic                found_q;
	logic [ADDR_W-1:0]   value_q;
	logic                adv_out;
	logic                adv_s2;
	logic                word_mode;
	logic [ADDR_W-1:0]   sx;
	logic [ADDR_W-1:0]   value_d;

	// Each stage moves on when the one after it is empty or moving.
	assign adv_out = !out_valid_q || !out_stall;
	assign adv_s2  = !valid_s2 || adv_out;
	assign busy    = valid_s1 && !adv_s2;

	// Modes that read the embedded word.
	always_comb begin
		case (mode)
			MODE_REL, MODE_WORD: word_mode = 1'b1;
			default:             word_mode = 1'b0;
		endcase
	end

	assign sx = {{(ADDR_W - WORD_W){item_s1.word[WORD_W-1]}}, item_s1.word};

	// Final selection of the result value.
	always_comb begin
		if (!found_s2) begin
			value_d = '0;
		end else begin
			case (mode)
				MODE_REL:  value_d = addr_s2 + rel_s2;
				MODE_WORD: value_d = sx_s2;
				default:   value_d = addr_s2;
			endcase
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy) begin
				valid_s1 <= load;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Stage one: the captured scan item.
	always_ff @(posedge clk) begin
		if (!busy && load) begin
			item_s1 <= item;
		end
	end

	// Stage two: match address, sign-extended word and its biased form.
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			found_s2 <= item_s1.hit && (!word_mode || item_s1.word_ok);
			addr_s2  <= start + item_s1.seen - ADDR_W'(len);
			sx_s2    <= sx;
			rel_s2   <= sx + WORD_BIAS;
		end
	end

	// Output register, held while the consumer stalls.
	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			found_q <= found_s2;
			value_q <= value_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign result_value = value_q;

endmodule
